FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CCD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion violated");

// next-cycle implication
`define CCD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion violated");

`endif

FILE: rtl/ccd_pkg.sv
// Package for the complex correlate and detect gate.
// Holds widths, register indexes, command codes and the control structs.
`timescale 1ns / 1ps
package ccd_pkg;

	localparam int MAX_TAPS_DEF    = 32;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int CORR_W = 38;
	localparam int HALF_W = CORR_W / 2;
	localparam int MAG_W  = 2 * CORR_W;
	localparam int THR_W  = 17;
	localparam int TIU_W  = 6;
	localparam int EXT_W  = 16;
	localparam int RHS_W  = 2 * THR_W + 28;

	// register indexes on the configuration port
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_TAPS      = 2'd1;
	localparam logic [1:0] REG_EXTRACT   = 2'd2;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);
	localparam logic [TIU_W-1:0] TIU_RESET = TIU_W'(32);
	localparam logic [EXT_W-1:0] EXT_RESET = '0;

	// request kinds
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TAP    = 1'b1;

	// magnitude sequence steps on the shared multiplier
	localparam logic [2:0] MS_RE_LL = 3'd0;
	localparam logic [2:0] MS_RE_HL = 3'd1;
	localparam logic [2:0] MS_RE_HH = 3'd2;
	localparam logic [2:0] MS_IM_LL = 3'd3;
	localparam logic [2:0] MS_IM_HL = 3'd4;
	localparam logic [2:0] MS_IM_HH = 3'd5;
	localparam logic [2:0] MS_THR   = 3'd6;
	localparam logic [2:0] MS_LAST  = MS_THR;

	typedef struct packed {
		logic       start;    // sample accepted: write window, arm MAC
		logic       tap_wr;   // tap write accepted
		logic       mac;      // issue one tap of the correlation
		logic       mul;      // issue one magnitude product
		logic [2:0] mstep;
		logic       out_load; // load the result register
	} cmd_t;

	typedef struct packed {
		logic last_tap;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/ccd_ctrl.sv
// Controller of the correlate and detect gate: sequences MAC, magnitude and output.
// Depends on ccd_pkg.
`timescale 1ns / 1ps
module ccd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          func,
	input  ccd_pkg::sts_t sts,
	output ccd_pkg::cmd_t cmd
);
	import ccd_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MAC    = 3'd1;
	localparam logic [2:0] ST_DRAIN1 = 3'd2;
	localparam logic [2:0] ST_DRAIN2 = 3'd3;
	localparam logic [2:0] ST_MAG    = 3'd4;
	localparam logic [2:0] ST_MWAIT  = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] mstep_q, mstep_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		mstep_d  = mstep_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (func == FUNC_TAP) begin
						cmd.tap_wr = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_MAC;
					end
				end
			end
			ST_MAC: begin
				cmd.mac = 1'b1;
				if (sts.last_tap) state_d = ST_DRAIN1;
			end
			ST_DRAIN1: state_d = ST_DRAIN2;
			ST_DRAIN2: begin
				state_d = ST_MAG;
				mstep_d = MS_RE_LL;
			end
			ST_MAG: begin
				cmd.mul   = 1'b1;
				cmd.mstep = mstep_q;
				if (mstep_q == MS_LAST) state_d = ST_MWAIT;
				else mstep_d = mstep_q + 3'd1;
			end
			ST_MWAIT: state_d = ST_OUT;
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mstep_q <= MS_RE_LL;
		end else begin
			state_q <= state_d;
			mstep_q <= mstep_d;
		end
	end

endmodule

FILE: rtl/ccd_dp.sv
// Datapath of the correlate and detect gate: window and tap memories, complex MAC,
// magnitude test, extraction gate and result register. Depends on ccd_pkg.
`timescale 1ns / 1ps
module ccd_dp #(
	parameter int MAX_TAPS    = ccd_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = ccd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ccd_pkg::cmd_t                     cmd,
	output ccd_pkg::sts_t                     sts,
	input  logic signed [SAMPLE_BITS-1:0]     sample_re,
	input  logic signed [SAMPLE_BITS-1:0]     sample_im,
	input  logic [4:0]                        tap_index,
	input  logic signed [SAMPLE_BITS-1:0]     tap_re,
	input  logic signed [SAMPLE_BITS-1:0]     tap_im,
	input  logic [ccd_pkg::THR_W-1:0]         threshold,
	input  logic [ccd_pkg::TIU_W-1:0]         taps_in_use,
	input  logic [ccd_pkg::EXT_W-1:0]         extract_length,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ccd_pkg::CORR_W-1:0] corr_re,
	output logic signed [ccd_pkg::CORR_W-1:0] corr_im,
	output logic                              window_full,
	output logic                              detected,
	output logic signed [SAMPLE_BITS-1:0]     delayed_re,
	output logic signed [SAMPLE_BITS-1:0]     delayed_im,
	output logic                              extract_valid
);
	import ccd_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int AW  = $clog2(MAX_TAPS);
	localparam int NW  = $clog2(MAX_TAPS + 1);
	localparam int CW  = (NW > TIU_W) ? NW : TIU_W;
	localparam int IXW = ((AW > 5) ? AW : 5) + 1;
	localparam int PW  = 2 * SB + 1;

	// memories
	logic [2*SB-1:0] win_mem [MAX_TAPS];
	logic [2*SB-1:0] tap_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0] tap_vld_q;

	logic [AW-1:0] wp_q, rp_q, age_q, tptr_q;
	logic [NW-1:0] fill_q, n_c;
	logic [CW-1:0] tiu_x;
	logic [AW:0]   old_sum;
	logic [IXW-1:0] tidx_x;

	// clamp taps in use to 1 .. MAX_TAPS
	always_comb begin
		tiu_x = CW'(taps_in_use);
		if (taps_in_use == '0) n_c = NW'(1);
		else if (tiu_x > CW'(MAX_TAPS)) n_c = NW'(MAX_TAPS);
		else n_c = NW'(tiu_x);
	end

	assign old_sum = (AW+1)'(wp_q) + (AW+1)'(MAX_TAPS) - (AW+1)'(n_c - NW'(1));
	assign tidx_x  = IXW'(tap_index);
	assign sts.last_tap = (tptr_q == AW'(n_c - NW'(1)));

	// tap writes
	always_ff @(posedge clk) begin
		if (cmd.tap_wr && tidx_x < IXW'(MAX_TAPS))
			tap_mem[AW'(tidx_x)] <= {tap_re, tap_im};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tap_vld_q <= '0;
		else if (cmd.tap_wr && tidx_x < IXW'(MAX_TAPS)) tap_vld_q[AW'(tidx_x)] <= 1'b1;
	end

	// window write at sample accept
	always_ff @(posedge clk) begin
		if (cmd.start) win_mem[wp_q] <= {sample_re, sample_im};
	end

	// window pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			age_q  <= '0;
			tptr_q <= '0;
			fill_q <= '0;
		end else if (cmd.start) begin
			wp_q   <= (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + AW'(1);
			rp_q   <= (old_sum >= (AW+1)'(MAX_TAPS)) ? AW'(old_sum - (AW+1)'(MAX_TAPS))
			                                          : AW'(old_sum);
			age_q  <= AW'(n_c - NW'(1));
			tptr_q <= '0;
			if (fill_q < NW'(MAX_TAPS)) fill_q <= fill_q + NW'(1);
		end else if (cmd.mac) begin
			rp_q   <= (rp_q == AW'(MAX_TAPS - 1)) ? '0 : rp_q + AW'(1);
			age_q  <= age_q - AW'(1);
			tptr_q <= tptr_q + AW'(1);
		end
	end

	// stage 1: registered memory reads
	logic [2*SB-1:0] win_rd_s1, tap_rd_s1;
	logic            win_ok_s1, tap_ok_s1, vld_s1, first_s1;

	always_ff @(posedge clk) begin
		win_rd_s1 <= win_mem[rp_q];
		tap_rd_s1 <= tap_mem[tptr_q];
		win_ok_s1 <= NW'(age_q) < fill_q;
		tap_ok_s1 <= tap_vld_q[tptr_q];
		first_s1  <= (tptr_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= cmd.mac;
	end

	logic signed [SB-1:0] a_c, b_c, c_c, d_c;
	logic signed [2*SB-1:0] p_ac, p_bd, p_bc, p_ad;

	// entries never written read as zero
	assign a_c  = win_ok_s1 ? $signed(win_rd_s1[2*SB-1:SB]) : '0;
	assign b_c  = win_ok_s1 ? $signed(win_rd_s1[SB-1:0])    : '0;
	assign c_c  = tap_ok_s1 ? $signed(tap_rd_s1[2*SB-1:SB]) : '0;
	assign d_c  = tap_ok_s1 ? $signed(tap_rd_s1[SB-1:0])    : '0;
	assign p_ac = a_c * c_c;
	assign p_bd = b_c * d_c;
	assign p_bc = b_c * c_c;
	assign p_ad = a_c * d_c;

	// stage 2: conjugate product terms
	logic signed [PW-1:0] pre_s2, pim_s2;
	logic                 vld_s2;
	logic signed [SB-1:0] dly_re_q, dly_im_q;

	always_ff @(posedge clk) begin
		pre_s2 <= $signed({p_ac[2*SB-1], p_ac}) + $signed({p_bd[2*SB-1], p_bd});
		pim_s2 <= $signed({p_bc[2*SB-1], p_bc}) - $signed({p_ad[2*SB-1], p_ad});
		if (vld_s1 && first_s1) begin
			dly_re_q <= a_c;
			dly_im_q <= b_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end

	// accumulators, wrapping at the correlation width
	logic signed [CORR_W-1:0] acc_re_q, acc_im_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (vld_s2) begin
			acc_re_q <= acc_re_q + CORR_W'(pre_s2);
			acc_im_q <= acc_im_q + CORR_W'(pim_s2);
		end
	end

	// magnitude: squares built from half-width products on one multiplier
	logic [CORR_W-1:0] ar_c, ai_c;
	logic [HALF_W-1:0] ma_c, mb_c;
	logic [2*HALF_W-1:0] mul_s1;
	logic [2:0]        mcode_s1;
	logic              mvld_s1;
	logic [MAG_W-1:0]  mag_q;
	logic [RHS_W-1:0]  rhs_q;

	assign ar_c = acc_re_q[CORR_W-1] ? CORR_W'(-acc_re_q) : CORR_W'(acc_re_q);
	assign ai_c = acc_im_q[CORR_W-1] ? CORR_W'(-acc_im_q) : CORR_W'(acc_im_q);

	always_comb begin
		case (cmd.mstep)
			MS_RE_LL: begin ma_c = ar_c[HALF_W-1:0];      mb_c = ar_c[HALF_W-1:0]; end
			MS_RE_HL: begin ma_c = ar_c[CORR_W-1:HALF_W]; mb_c = ar_c[HALF_W-1:0]; end
			MS_RE_HH: begin ma_c = ar_c[CORR_W-1:HALF_W]; mb_c = ar_c[CORR_W-1:HALF_W]; end
			MS_IM_LL: begin ma_c = ai_c[HALF_W-1:0];      mb_c = ai_c[HALF_W-1:0]; end
			MS_IM_HL: begin ma_c = ai_c[CORR_W-1:HALF_W]; mb_c = ai_c[HALF_W-1:0]; end
			MS_IM_HH: begin ma_c = ai_c[CORR_W-1:HALF_W]; mb_c = ai_c[CORR_W-1:HALF_W]; end
			MS_THR:   begin ma_c = HALF_W'(threshold);    mb_c = HALF_W'(threshold); end
			default:  begin ma_c = '0;                    mb_c = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_s1   <= ma_c * mb_c;
		mcode_s1 <= cmd.mstep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mvld_s1 <= 1'b0;
		else mvld_s1 <= cmd.mul;
	end

	// fold products into the sum of squares and load the squared threshold
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mag_q <= '0;
		end else if (mvld_s1) begin
			case (mcode_s1)
				MS_RE_LL, MS_IM_LL: mag_q <= mag_q + MAG_W'(mul_s1);
				MS_RE_HL, MS_IM_HL: mag_q <= mag_q + (MAG_W'(mul_s1) << (HALF_W + 1));
				MS_RE_HH, MS_IM_HH: mag_q <= mag_q + (MAG_W'(mul_s1) << CORR_W);
				MS_THR:             rhs_q <= RHS_W'(mul_s1) << 28;
				default:            mag_q <= mag_q;
			endcase
		end
	end

	// detection and extraction gate
	logic             full_c, det_c, gate_q, gate_n, valid_n;
	logic [EXT_W-1:0] passed_q, passed_n;

	assign full_c = fill_q >= n_c;
	assign det_c  = full_c && (mag_q >= MAG_W'(rhs_q));

	always_comb begin
		gate_n   = gate_q;
		passed_n = passed_q;
		if (!gate_q && det_c) begin
			gate_n   = 1'b1;
			passed_n = '0;
		end
		valid_n = gate_n;
		if (gate_n) begin
			if (passed_n != '1) passed_n = passed_n + EXT_W'(1);
			if (extract_length != '0 && passed_n >= extract_length) gate_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q   <= 1'b0;
			passed_q <= '0;
		end else if (cmd.out_load) begin
			gate_q   <= gate_n;
			passed_q <= passed_n;
		end
	end

	// result register
	assign sts.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			corr_re       <= acc_re_q;
			corr_im       <= acc_im_q;
			window_full   <= full_c;
			detected      <= det_c;
			delayed_re    <= dly_re_q;
			delayed_im    <= dly_im_q;
			extract_valid <= valid_n;
		end
	end

endmodule

FILE: rtl/complex_correlate_detect_gate.sv
// Top level of the complex correlate and detect gate: configuration registers,
// controller and datapath. Depends on ccd_pkg, ccd_ctrl and ccd_dp.
//
//  channel  | handshake          | carries
//  ---------+--------------------+-------------------------------------------
//  config   | psel/penable/pready| threshold, taps_in_use, extract_length
//  input    | in_valid/in_ready  | func, sample_re/im, tap_index, tap_re/im
//  output   | out_valid/out_ready| corr, window_full, detected, delayed, valid
//
// A tap write leaves the block idle and ready. A sample runs from acceptance to a
// loaded result through the shared complex MAC, one tap per cycle over the n taps
// in use, then seven steps of the single magnitude multiplier.
// One sample is in flight at a time; the result register lets the next request
// in while the previous result waits on out_ready.
// Reset is asynchronous and clears pointers, tap valid bits, gate and counters.
`timescale 1ns / 1ps
module complex_correlate_detect_gate #(
	parameter int MAX_TAPS    = ccd_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = ccd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [3:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic signed [SAMPLE_BITS-1:0]     sample_re,
	input  logic signed [SAMPLE_BITS-1:0]     sample_im,
	input  logic [4:0]                        tap_index,
	input  logic signed [SAMPLE_BITS-1:0]     tap_re,
	input  logic signed [SAMPLE_BITS-1:0]     tap_im,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ccd_pkg::CORR_W-1:0] corr_re,
	output logic signed [ccd_pkg::CORR_W-1:0] corr_im,
	output logic                              window_full,
	output logic                              detected,
	output logic signed [SAMPLE_BITS-1:0]     delayed_re,
	output logic signed [SAMPLE_BITS-1:0]     delayed_im,
	output logic                              extract_valid
);
	import ccd_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic [TIU_W-1:0] tiu_q;
	logic [EXT_W-1:0] ext_q;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			tiu_q <= TIU_RESET;
			ext_q <= EXT_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_THRESHOLD: thr_q <= pwdata[THR_W-1:0];
				REG_TAPS:      tiu_q <= pwdata[TIU_W-1:0];
				REG_EXTRACT:   ext_q <= pwdata[EXT_W-1:0];
				default:       thr_q <= thr_q;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[3:2])
			REG_THRESHOLD: prdata = 32'(thr_q);
			REG_TAPS:      prdata = 32'(tiu_q);
			REG_EXTRACT:   prdata = 32'(ext_q);
			default:       prdata = '0;
		endcase
	end

	ccd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.sts      (sts),
		.cmd      (cmd)
	);

	ccd_dp #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.sample_re      (sample_re),
		.sample_im      (sample_im),
		.tap_index      (tap_index),
		.tap_re         (tap_re),
		.tap_im         (tap_im),
		.threshold      (thr_q),
		.taps_in_use    (tiu_q),
		.extract_length (ext_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.corr_re        (corr_re),
		.corr_im        (corr_im),
		.window_full    (window_full),
		.detected       (detected),
		.delayed_re     (delayed_re),
		.delayed_im     (delayed_im),
		.extract_valid  (extract_valid)
	);

endmodule

FILE: rtl/ccd_chk.sv
// Port-level checker for the complex correlate and detect gate, bound to the top.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ccd_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic func,
	input logic out_valid,
	input logic out_ready,
	input logic window_full,
	input logic detected
);

	// a result waiting on the consumer is held
	`CCD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// detection needs a full window
	`CCD_ASSERT_IMP(a_det_full, clk, arst_n, out_valid && detected, window_full)
	// a sample request keeps the block busy for the next cycle
	`CCD_ASSERT_NXT(a_busy, clk, arst_n, in_valid && in_ready && !func, !in_ready)
	// a tap write completes at once and leaves the block ready
	`CCD_ASSERT_NXT(a_tap_ready, clk, arst_n, in_valid && in_ready && func, in_ready)

endmodule

bind complex_correlate_detect_gate ccd_chk u_chk (.*);

FILE: tb/complex_correlate_detect_gate_tb.sv
// Testbench for complex_correlate_detect_gate: streams samples and tap writes through the
// valid/ready request channel, programs the APB registers between phases and checks every
// result against a local predictor or a typed expectation. Depends on ccd_pkg and the RTL only.
`timescale 1ns / 1ps
module complex_correlate_detect_gate_tb;
	import ccd_pkg::*;

	localparam int NTAPS = 32;
	localparam int LIMIT = 600000;
	localparam int SETTLE = 60;

	typedef struct packed {
		logic signed [CORR_W-1:0] c_re;
		logic signed [CORR_W-1:0] c_im;
		logic                     full;
		logic                     det;
		logic signed [15:0]       d_re;
		logic signed [15:0]       d_im;
		logic                     xvalid;
	} corr_res_t;

	typedef struct {
		logic               f;
		logic signed [15:0] s_re;
		logic signed [15:0] s_im;
		logic [4:0]         idx;
		logic signed [15:0] t_re;
		logic signed [15:0] t_im;
		bit                 typed;
	} stim_row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_ready, func;
	logic signed [15:0] sample_re, sample_im, tap_re, tap_im;
	logic [4:0] tap_index;
	logic out_valid, out_ready;
	logic signed [CORR_W-1:0] corr_re, corr_im;
	logic window_full, detected, extract_valid;
	logic signed [15:0] delayed_re, delayed_im;

	// typed expectation travels with the request it belongs to
	logic hold_typed;
	corr_res_t hold_res;

	complex_correlate_detect_gate uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.sample_re(sample_re), .sample_im(sample_im), .tap_index(tap_index),
		.tap_re(tap_re), .tap_im(tap_im),
		.out_valid(out_valid), .out_ready(out_ready),
		.corr_re(corr_re), .corr_im(corr_im), .window_full(window_full),
		.detected(detected), .delayed_re(delayed_re), .delayed_im(delayed_im),
		.extract_valid(extract_valid)
	);

	// predictor state
	logic signed [15:0] win_re [NTAPS];
	logic signed [15:0] win_im [NTAPS];
	logic signed [15:0] ref_tap_re [NTAPS];
	logic signed [15:0] ref_tap_im [NTAPS];
	int fill_cnt, pass_cnt;
	bit gate_is_open;
	logic [THR_W-1:0] cfg_thr;
	logic [TIU_W-1:0] cfg_taps;
	logic [EXT_W-1:0] cfg_ext;

	corr_res_t corr_expected[$];
	int errors, cycles, n_samples, n_tapwr, n_det, n_extract;
	bit no_idle;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int taps_effective();
		if (cfg_taps == 0) return 1;
		if (cfg_taps > NTAPS) return NTAPS;
		return int'(cfg_taps);
	endfunction

	// shift in one sample, correlate against conjugated taps, run detector and gate
	task automatic correlate_sample(input logic signed [15:0] re, input logic signed [15:0] im,
			output corr_res_t r);
		int n;
		longint acc_re, acc_im, a, b, c, d;
		logic signed [79:0] sre, sim, mag;
		logic [79:0] lim;
		for (int j = NTAPS - 1; j > 0; j--) begin
			win_re[j] = win_re[j-1];
			win_im[j] = win_im[j-1];
		end
		win_re[0] = re;
		win_im[0] = im;
		if (fill_cnt < NTAPS) fill_cnt++;
		n = taps_effective();
		acc_re = 0;
		acc_im = 0;
		for (int j = 0; j < n; j++) begin
			a = win_re[n-1-j];
			b = win_im[n-1-j];
			c = ref_tap_re[j];
			d = ref_tap_im[j];
			acc_re += a * c + b * d;
			acc_im += b * c - a * d;
		end
		r.c_re = acc_re[CORR_W-1:0];
		r.c_im = acc_im[CORR_W-1:0];
		r.full = (fill_cnt >= n);
		sre = r.c_re;
		sim = r.c_im;
		mag = sre * sre + sim * sim;
		lim = cfg_thr;
		lim = (lim * lim) << 28;
		r.det = r.full && ($unsigned(mag) >= lim);
		if (!gate_is_open && r.det) begin
			gate_is_open = 1'b1;
			pass_cnt = 0;
		end
		r.xvalid = gate_is_open;
		if (gate_is_open) begin
			if (pass_cnt < 65535) pass_cnt++;
			if (cfg_ext != 0 && pass_cnt >= cfg_ext) gate_is_open = 1'b0;
		end
		r.d_re = win_re[n-1];
		r.d_im = win_im[n-1];
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	// request acceptance: predict; result acceptance: compare
	always @(posedge clk) begin
		corr_res_t r, e;
		if (arst_n && in_valid && in_ready) begin
			if (func == FUNC_TAP) begin
				ref_tap_re[tap_index] = tap_re;
				ref_tap_im[tap_index] = tap_im;
				n_tapwr++;
			end else begin
				correlate_sample(sample_re, sample_im, r);
				corr_expected.push_back(hold_typed ? hold_res : r);
				n_samples++;
			end
		end
		if (arst_n && out_valid && out_ready) begin
			if (corr_expected.size() == 0) begin
				report("result with none expected", corr_re, 0);
			end else begin
				e = corr_expected.pop_front();
				if (corr_re !== e.c_re) report("corr_re", corr_re, e.c_re);
				if (corr_im !== e.c_im) report("corr_im", corr_im, e.c_im);
				if (window_full !== e.full) report("window_full", window_full, e.full);
				if (detected !== e.det) report("detected", detected, e.det);
				if (delayed_re !== e.d_re) report("delayed_re", delayed_re, e.d_re);
				if (delayed_im !== e.d_im) report("delayed_im", delayed_im, e.d_im);
				if (extract_valid !== e.xvalid) report("extract_valid", extract_valid, e.xvalid);
				n_det += detected;
				n_extract += extract_valid;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("complex_correlate_detect_gate: mismatch");
			$finish;
		end
	end

	// receiver back-pressure in random bursts
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!no_idle && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_THRESHOLD: cfg_thr = val[THR_W-1:0];
			REG_TAPS:      cfg_taps = val[TIU_W-1:0];
			REG_EXTRACT:   cfg_ext = val[EXT_W-1:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		// the bus goes idle before the next transfer
		@(posedge clk);
	endtask

	task automatic send(input logic f, input logic signed [15:0] s_re, input logic signed [15:0] s_im,
			input logic [4:0] idx, input logic signed [15:0] t_re, input logic signed [15:0] t_im,
			input bit typed, input corr_res_t res);
		if (!no_idle && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		func <= f;
		sample_re <= s_re;
		sample_im <= s_im;
		tap_index <= idx;
		tap_re <= t_re;
		tap_im <= t_im;
		hold_typed <= typed;
		hold_res <= res;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// sender holds off until every result is back, then the block settles
	task automatic drain();
		in_valid <= 1'b0;
		while (corr_expected.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick16();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1: return 16'($signed($urandom_range(0, 2047)) - 1024);
			default: return 16'($urandom);
		endcase
	endfunction

	stim_row_t directed[12] = '{
		'{FUNC_SAMPLE, 16'sh7FFF, 16'sh8000, 5'd0, 16'sh0, 16'sh0, 1'b1},
		'{FUNC_SAMPLE, 16'sh8000, 16'sh7FFF, 5'd31, 16'sh7FFF, 16'sh7FFF, 1'b1},
		'{FUNC_SAMPLE, 16'sh0000, 16'sh0000, 5'd0, 16'sh0, 16'sh0, 1'b1},
		'{FUNC_SAMPLE, 16'shFFFF, 16'sh0001, 5'd0, 16'sh0, 16'sh0, 1'b1},
		'{FUNC_TAP, 16'sh0, 16'sh0, 5'd0, 16'sh7FFF, 16'sh8000, 1'b0},
		'{FUNC_TAP, 16'sh0, 16'sh0, 5'd31, 16'sh8000, 16'sh7FFF, 1'b0},
		'{FUNC_TAP, 16'sh0, 16'sh0, 5'd15, 16'sh8000, 16'sh8000, 1'b0},
		'{FUNC_TAP, 16'sh0, 16'sh0, 5'd16, 16'sh7FFF, 16'sh7FFF, 1'b0},
		'{FUNC_SAMPLE, 16'sh7FFF, 16'sh7FFF, 5'd0, 16'sh0, 16'sh0, 1'b0},
		'{FUNC_SAMPLE, 16'sh8000, 16'sh8000, 5'd0, 16'sh0, 16'sh0, 1'b0},
		'{FUNC_SAMPLE, 16'sh5555, 16'shAAAA, 5'd10, 16'sh0, 16'sh0, 1'b0},
		'{FUNC_SAMPLE, 16'shAAAA, 16'sh5555, 5'd21, 16'sh0, 16'sh0, 1'b0}
	};

	// threshold, taps in use, extract length for each random phase
	int ph_thr[10] = '{0, 131071, 16384, 0, 65536, 8192, 40000, 24576, 12000, 32768};
	int ph_taps[10] = '{1, 32, 4, 0, 63, 8, 16, 2, 12, 32};
	int ph_ext[10] = '{1, 65535, 5, 0, 3, 2, 1, 0, 7, 20};

	initial begin
		corr_res_t zero_res;
		int sent, n;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; func = FUNC_SAMPLE; tap_index = '0;
		sample_re = '0; sample_im = '0; tap_re = '0; tap_im = '0;
		hold_typed = 1'b0; hold_res = '0;
		errors = 0; cycles = 0; n_samples = 0; n_tapwr = 0; n_det = 0; n_extract = 0;
		no_idle = 1'b0;
		fill_cnt = 0; pass_cnt = 0; gate_is_open = 1'b0;
		cfg_thr = THR_RESET; cfg_taps = TIU_RESET; cfg_ext = EXT_RESET;
		for (int i = 0; i < NTAPS; i++) begin
			win_re[i] = '0; win_im[i] = '0; ref_tap_re[i] = '0; ref_tap_im[i] = '0;
		end
		zero_res = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fresh from reset all taps are zero and the window is empty
		foreach (directed[i])
			send(directed[i].f, directed[i].s_re, directed[i].s_im, directed[i].idx,
				directed[i].t_re, directed[i].t_im, directed[i].typed, zero_res);
		drain();

		// random phases, each with its own register setting
		for (int p = 0; p < 10; p++) begin
			apb_write(REG_THRESHOLD, ph_thr[p]);
			apb_write(REG_TAPS, ph_taps[p]);
			apb_write(REG_EXTRACT, ph_ext[p]);
			if (p == 9) no_idle = 1'b1;
			n = taps_effective();
			sent = 0;
			while (sent < 150) begin
				case ($urandom_range(0, 9))
					0, 1: send(FUNC_TAP, pick16(), pick16(), 5'($urandom), pick16(), pick16(),
						1'b0, zero_res);
					2, 3, 4: begin
						// preamble: replay the taps so the peak lands on a full window
						for (int j = 0; j < n; j++)
							send(FUNC_SAMPLE, ref_tap_re[j], ref_tap_im[j], 5'($urandom),
								pick16(), pick16(), 1'b0, zero_res);
						sent += n;
					end
					default: begin
						send(FUNC_SAMPLE, pick16(), pick16(), 5'($urandom), pick16(), pick16(),
							1'b0, zero_res);
						sent++;
					end
				endcase
			end
			drain();
		end

		$display("covered %0d samples and %0d tap writes over 11 register settings",
			n_samples, n_tapwr);
		$display("saw %0d detections and %0d extracted samples", n_det, n_extract);
		if (errors == 0 && corr_expected.size() == 0) begin
			$display("complex_correlate_detect_gate: match");
		end else begin
			$display("complex_correlate_detect_gate: mismatch");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/ccd_pkg.sv
rtl/ccd_ctrl.sv
rtl/ccd_dp.sv
rtl/complex_correlate_detect_gate.sv
rtl/ccd_chk.sv
tb/complex_correlate_detect_gate_tb.sv
